// File: rtl/core/fmmc_pkg.sv
// ----------------------------------------------------------------------------
// fmmc_pkg
// Types, constants and message helpers for the footswitch MIDI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fmmc_pkg;

	// Scenes per folder and folder modes in use
	localparam logic [2:0] SCENE_COUNT  = 3'd6;
	localparam logic [2:0] FOLDER_COUNT = 3'd4;

	localparam int SAVE_SLOTS = 4;
	localparam int MSG_SLOTS  = 6;

	// Mode codes
	localparam logic [2:0] MODE_SETUP = 3'd4;
	localparam logic [2:0] MODE_LOOP  = 3'd5;

	// High nibbles of the status bytes
	localparam logic [3:0] ST_PC_HI = 4'hC;
	localparam logic [3:0] ST_CC_HI = 4'hB;

	// Controller numbers and values
	localparam logic [6:0] CC_TUNER     = 7'd69;
	localparam logic [6:0] CC_BYPASS    = 7'd23;
	localparam logic [6:0] CC_LOOPER    = 7'd86;
	localparam logic [6:0] CC_PLAY_STOP = 7'd28;
	localparam logic [6:0] CC_REC_OVER  = 7'd50;
	localparam logic [6:0] CC_ON        = 7'd64;
	localparam logic [6:0] CC_OFF       = 7'd0;

	// LED bits
	localparam int LED_A = 4;
	localparam int LED_B = 5;

	// Press latch bits
	localparam int LATCH_A   = 0;
	localparam int LATCH_B   = 1;
	localparam int LATCH_SEL = 2;

	// Reset values
	localparam logic [2:0]  MODE_RST    = MODE_SETUP;
	localparam logic [5:0]  LED_RST     = 6'd6;
	localparam logic [15:0] HOLD_RST    = 16'd500;
	localparam logic [2:0]  SAVED_RST   = 3'd1;

	typedef enum logic [1:0] {
		CFG_HOLD_TICKS   = 2'd0,
		CFG_MIDI_CHANNEL = 2'd1,
		CFG_LOOPER_EN    = 2'd2
	} cfg_idx_t;

	typedef logic [2:0] scene_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  scene;
		logic [5:0]  led;
		logic [2:0]  latch;
		logic [15:0] hold;
		logic        loop_en;
		logic        loop_act;
	} fmmc_state_t;

	typedef struct packed {
		logic       vld;
		logic       cc;
		logic [6:0] d1;
		logic [6:0] d2;
	} msg_t;

	typedef struct packed {
		logic       we;
		logic [1:0] idx;
		scene_t     val;
	} save_wr_t;

	function automatic msg_t mk_cc(input logic [6:0] ctl, input logic [6:0] val);
		msg_t m;
		m.vld = 1'b1;
		m.cc  = 1'b1;
		m.d1  = ctl;
		m.d2  = val;
		return m;
	endfunction

	// Program number: mode * scenes + scene - 1, kept to seven bits
	function automatic msg_t mk_pc(input logic [2:0] mode, input scene_t scene);
		msg_t       m;
		logic [7:0] prog;
		prog  = 8'(mode) * 8'(SCENE_COUNT) + 8'(scene) + 8'd127;
		m.vld = 1'b1;
		m.cc  = 1'b0;
		m.d1  = prog[6:0];
		m.d2  = 7'd0;
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/fmmc_step.sv
// ----------------------------------------------------------------------------
// fmmc_step
// Next state and message list for one footswitch tick.
// ----------------------------------------------------------------------------
`default_nettype none

module fmmc_step
	import fmmc_pkg::*;
(
	input  fmmc_state_t cur,
	input  scene_t      saved_scene [SAVE_SLOTS],
	input  logic        pedal_a,
	input  logic        pedal_b,
	input  logic        pedal_sel,
	input  logic [15:0] hold_ticks,
	output fmmc_state_t nxt,
	output save_wr_t    save_wr,
	output logic        pulse,
	output msg_t        msgs [MSG_SLOTS],
	output logic [2:0]  msg_count
);

	msg_t cand [MSG_SLOTS];

	always_comb begin
		fmmc_state_t st;
		logic [3:0]  m;
		scene_t      sc;
		logic [3:0]  up;
		st      = cur;
		m       = 4'd0;
		sc      = 3'd0;
		up      = 4'd0;
		pulse   = 1'b0;
		save_wr = '0;
		for (int i = 0; i < MSG_SLOTS; i++) begin
			cand[i] = '0;
		end

		// press phase
		if (pedal_a) begin
			st.latch[LATCH_A] = 1'b1;
			if (st.mode < MODE_SETUP && !st.led[LED_A]) begin
				st.led[LED_A] = 1'b1;
				st.led[LED_B] = 1'b0;
			end
		end
		if (pedal_b) begin
			st.latch[LATCH_B] = 1'b1;
			if (st.mode < MODE_SETUP && !st.led[LED_B]) begin
				st.led[LED_B] = 1'b1;
				st.led[LED_A] = 1'b0;
			end
		end
		if (pedal_sel) begin
			st.latch[LATCH_SEL] = 1'b1;
			if (st.hold != 16'hFFFF) st.hold = st.hold + 16'd1;
			if (st.hold >= hold_ticks) begin
				if (st.mode < MODE_SETUP) begin
					st.latch[LATCH_SEL] = 1'b0;
					save_wr.we  = 1'b1;
					save_wr.idx = st.mode[1:0];
					save_wr.val = st.scene;
					st.hold     = 16'd0;
					pulse       = 1'b1;
				end else if (st.mode == MODE_SETUP) begin
					st.latch[LATCH_SEL] = 1'b0;
					st.loop_en = ~st.loop_en;
					st.hold    = 16'd0;
					pulse      = 1'b1;
				end
			end
		end else begin
			st.hold = 16'd0;
		end

		// up release
		if (!pedal_a && st.latch[LATCH_A]) begin
			st.latch[LATCH_A] = 1'b0;
			if (st.mode != MODE_LOOP) st.led[LED_B] = 1'b0;
			if (st.mode < MODE_SETUP) st.led[LED_A] = 1'b0;
			else st.led[LED_A] = ~st.led[LED_A];
			if (st.mode < FOLDER_COUNT && st.mode < MODE_SETUP) begin
				up = {1'b0, st.scene} + 4'd1;
				st.scene = (up > {1'b0, SCENE_COUNT}) ? 3'd1 : up[2:0];
				cand[0] = mk_pc(st.mode, st.scene);
			end else if (st.mode == MODE_SETUP) begin
				if (st.led[LED_A]) begin
					cand[0] = mk_cc(CC_TUNER, CC_OFF);
					cand[1] = mk_cc(CC_BYPASS, CC_ON);
				end else begin
					cand[0] = mk_cc(CC_BYPASS, CC_OFF);
				end
			end else if (st.mode == MODE_LOOP) begin
				if (st.led[LED_A] && st.led[LED_B]) begin
					cand[0] = mk_cc(CC_LOOPER, CC_OFF);
					cand[1] = mk_cc(CC_REC_OVER, CC_OFF);
					st.loop_act = 1'b0;
				end else if (st.led[LED_A]) begin
					st.led[LED_B] = 1'b0;
					cand[0] = mk_cc(CC_REC_OVER, CC_ON);
				end else begin
					if (!st.loop_act) begin
						cand[0] = mk_cc(CC_LOOPER, CC_ON);
						st.loop_act = 1'b1;
					end
					st.led[LED_B] = 1'b0;
					cand[1] = mk_cc(CC_PLAY_STOP, CC_OFF);
				end
			end
		end

		// down release
		if (!pedal_b && st.latch[LATCH_B]) begin
			st.latch[LATCH_B] = 1'b0;
			st.led[LED_A] = 1'b0;
			if (st.mode < MODE_SETUP) st.led[LED_B] = 1'b0;
			else st.led[LED_B] = ~st.led[LED_B];
			if (st.mode < FOLDER_COUNT && st.mode < MODE_SETUP) begin
				st.scene = (st.scene <= 3'd1) ? SCENE_COUNT : st.scene - 3'd1;
				cand[2] = mk_pc(st.mode, st.scene);
			end else if (st.mode == MODE_SETUP) begin
				if (st.led[LED_B]) begin
					cand[2] = mk_cc(CC_BYPASS, CC_OFF);
					cand[3] = mk_cc(CC_TUNER, CC_ON);
				end else begin
					cand[2] = mk_cc(CC_TUNER, CC_OFF);
				end
			end else if (st.mode == MODE_LOOP) begin
				if (st.led[LED_B]) begin
					cand[2] = mk_cc(CC_PLAY_STOP, CC_ON);
				end else begin
					if (!st.loop_act) begin
						cand[2] = mk_cc(CC_LOOPER, CC_ON);
						st.loop_act = 1'b1;
					end
					cand[3] = mk_cc(CC_PLAY_STOP, CC_OFF);
				end
			end
		end

		// select release: advance the mode
		if (!pedal_sel && st.latch[LATCH_SEL]) begin
			st.latch[LATCH_SEL] = 1'b0;
			m = {1'b0, st.mode} + 4'd1;
			if (m == {1'b0, FOLDER_COUNT} && m < {1'b0, MODE_SETUP}) m = {1'b0, MODE_SETUP};
			if (st.loop_en) begin
				if (m > {1'b0, MODE_LOOP}) m = 4'd0;
			end else if (m > {1'b0, MODE_SETUP}) begin
				m = 4'd0;
			end
			st.mode = m[2:0];
			st.hold = 16'd0;
			if (st.loop_act) begin
				st.loop_act = 1'b0;
				cand[4] = mk_cc(CC_LOOPER, CC_OFF);
			end
			if (m < {1'b0, MODE_SETUP}) begin
				sc = saved_scene[m[1:0]];
				st.scene = (sc == 3'd0 || sc > SCENE_COUNT) ? 3'd1 : sc;
			end else begin
				st.scene = 3'd1;
			end
			case (m[2:0])
				3'd0:       st.led = 6'd1;
				3'd1:       st.led = 6'd2;
				3'd2:       st.led = 6'd4;
				3'd3:       st.led = 6'd5;
				MODE_SETUP: st.led = 6'd7;
				default:    st.led = 6'd3;
			endcase
			if (m < {1'b0, FOLDER_COUNT} && m < {1'b0, MODE_SETUP}) begin
				cand[5] = mk_pc(m[2:0], st.scene);
			end
			if (m == {1'b0, MODE_LOOP}) begin
				cand[5] = mk_cc(CC_LOOPER, CC_ON);
				st.loop_act = 1'b1;
			end
		end

		nxt = st;
	end

	// Pack the messages in send order
	always_comb begin
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 0; i < MSG_SLOTS; i++) begin
			msgs[i] = '0;
		end
		for (int i = 0; i < MSG_SLOTS; i++) begin
			if (cand[i].vld) begin
				msgs[pos] = cand[i];
				pos = pos + 3'd1;
			end
		end
		msg_count = pos;
	end

endmodule

`default_nettype wire

// File: rtl/core/footswitch_midi_mode_controller_core.sv
// ----------------------------------------------------------------------------
// footswitch_midi_mode_controller_core
// Mode, scene and LED controller for a three-switch MIDI footswitch.
// ----------------------------------------------------------------------------
// Each accepted input item is one 10 ms tick with the levels of the up, down
// and select switches. The whole tick is evaluated in the cycle it is
// accepted: mode, scene, LEDs, latches, hold counter, looper flags and saved
// scenes are updated at once, and the tick's results are loaded into a result
// register. A tick then yields 1 + n result items, n = 0..6 MIDI messages:
// first a status item (no message, end-of-tick LEDs, mode and save pulse),
// then the messages in send order, last_item set on the final one. The single
// output port moves one item per cycle while out_ready is high; the next tick
// is accepted in the cycle its predecessor's last item is taken, so ticks may
// follow back to back. Configuration is taken at any time (cfg_ready is always
// high) but must only be written while idle.
// Writing the CFG_LOOPER_EN entry loads the live looper enable flag directly.
// ----------------------------------------------------------------------------
`default_nettype none

module footswitch_midi_mode_controller_core
	import fmmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        pedal_a,
	input  logic        pedal_b,
	input  logic        pedal_sel,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        msg_valid,
	output logic [7:0]  msg_status,
	output logic [6:0]  msg_data1,
	output logic [6:0]  msg_data2,
	output logic        msg_three_bytes,
	output logic [5:0]  led_pattern,
	output logic [2:0]  mode_now,
	output logic        save_pulse,
	output logic        last_item,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	logic [15:0] hold_ticks_q;
	logic [3:0]  channel_q;

	// Controller state and saved scene per folder
	fmmc_state_t st_q;
	scene_t      saved_q [SAVE_SLOTS];

	// Result register for the tick being drained
	msg_t        msg_q [MSG_SLOTS];
	logic [2:0]  cnt_q;
	logic [5:0]  led_q;
	logic [2:0]  mode_q;
	logic        pulse_q;
	logic        busy_q;
	logic [2:0]  idx_q;

	// Step outputs
	fmmc_state_t st_nxt;
	save_wr_t    save_wr;
	logic        pulse_nxt;
	msg_t        msgs_nxt [MSG_SLOTS];
	logic [2:0]  cnt_nxt;

	logic        in_fire;
	logic        out_fire;
	logic        cfg_fire;
	logic        is_last;
	msg_t        cur_msg;

	fmmc_step u_step (
		.cur         (st_q),
		.saved_scene (saved_q),
		.pedal_a     (pedal_a),
		.pedal_b     (pedal_b),
		.pedal_sel   (pedal_sel),
		.hold_ticks  (hold_ticks_q),
		.nxt         (st_nxt),
		.save_wr     (save_wr),
		.pulse       (pulse_nxt),
		.msgs        (msgs_nxt),
		.msg_count   (cnt_nxt)
	);

	// Handshakes: take a new tick when idle or when the last item leaves
	assign is_last   = (idx_q == cnt_q);
	assign out_valid = busy_q;
	assign out_fire  = busy_q && out_ready;
	assign in_ready  = !busy_q || (out_ready && is_last);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q   <= HOLD_RST;
			channel_q      <= 4'd0;
			st_q.mode      <= MODE_RST;
			st_q.scene     <= 3'd0;
			st_q.led       <= LED_RST;
			st_q.latch     <= 3'd0;
			st_q.hold      <= 16'd0;
			st_q.loop_en   <= 1'b1;
			st_q.loop_act  <= 1'b0;
			for (int i = 0; i < SAVE_SLOTS; i++) begin
				saved_q[i] <= SAVED_RST;
			end
		end else begin
			if (in_fire) begin
				st_q <= st_nxt;
				if (save_wr.we) saved_q[save_wr.idx] <= save_wr.val;
			end
			// config is to be written only while idle (not enforced); it wins
			if (cfg_fire) begin
				case (cfg_idx_t'(cfg_index))
					CFG_HOLD_TICKS:   hold_ticks_q <= cfg_data;
					CFG_MIDI_CHANNEL: channel_q    <= cfg_data[3:0];
					CFG_LOOPER_EN:    st_q.loop_en <= cfg_data[0];
					default:          ;
				endcase
			end
		end
	end

	// Output sequencing: hold the tick's results, advance one item per cycle while out_ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (out_fire) begin
				if (is_last) busy_q <= 1'b0;
				else idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Result payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			msg_q   <= msgs_nxt;
			cnt_q   <= cnt_nxt;
			led_q   <= st_nxt.led;
			mode_q  <= st_nxt.mode;
			pulse_q <= pulse_nxt;
		end
	end

	// Item 0 is the status item; items 1..n carry the messages
	always_comb begin
		cur_msg = '0;
		if (idx_q != 3'd0) cur_msg = msg_q[idx_q - 3'd1];
	end

	assign msg_valid       = cur_msg.vld;
	assign msg_status      = cur_msg.vld ? {(cur_msg.cc ? ST_CC_HI : ST_PC_HI), channel_q} : 8'd0;
	assign msg_data1       = cur_msg.d1;
	assign msg_data2       = cur_msg.d2;
	assign msg_three_bytes = cur_msg.cc;
	assign led_pattern     = led_q;
	assign mode_now        = mode_q;
	assign save_pulse      = pulse_q;
	assign last_item       = is_last;

	// Checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= cnt_q))
		else $error("item index beyond message count");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (out_valid && idx_q == 3'd0))
		else $error("accepted tick did not start at its status item");

	a_overlap_only_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && out_valid) |-> (last_item && out_ready))
		else $error("new tick taken while results still pending");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode_now != 3'd6 && mode_now != 3'd7))
		else $error("mode out of range");

endmodule

`default_nettype wire
